// File: rtl/png_scanline_unfilter_assert.svh
// Assertion macros used by the unfilter back end.
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("psu: implication violated");

// The consequent must hold in the cycle after the antecedent.
`define PSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("psu: next-cycle implication violated");

`endif

// File: rtl/psu_pkg.sv
// Shared types, codes and the Paeth predictor for the scanline unfilter.
`default_nettype none
package psu_pkg;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [7:0] FILT_CODE_MAX = 8'd4;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PIXB   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Byte lane within a pixel, enough for up to four bytes per pixel.
    localparam int LANE_W = 2;

    typedef struct packed {
        logic              bad;
        logic [7:0]        data;
        logic [2:0]        filter;
        logic [LANE_W-1:0] lane;
        logic              above_zero;
        logic              first;
        logic              row_end;
        logic              image_end;
    } t_item;

    function automatic logic [7:0] paeth_pred(input logic [7:0] a,
                                              input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] sa;
        logic signed [10:0] sb;
        logic signed [10:0] sc;
        logic signed [10:0] dbc;
        logic signed [10:0] dac;
        logic signed [10:0] dsum;
        logic [10:0]        pa;
        logic [10:0]        pb;
        logic [10:0]        pc;
        logic [7:0]         res;
        sa   = $signed({3'b000, a});
        sb   = $signed({3'b000, b});
        sc   = $signed({3'b000, c});
        dbc  = sb - sc;
        dac  = sa - sc;
        dsum = dbc + dac;
        pa   = dbc[10]  ? $unsigned(-dbc)  : $unsigned(dbc);
        pb   = dac[10]  ? $unsigned(-dac)  : $unsigned(dac);
        pc   = dsum[10] ? $unsigned(-dsum) : $unsigned(dsum);
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/png_scanline_unfilter.sv
// Top level of the streaming PNG scanline unfilter for 8-bit samples.
`default_nettype none
// The block takes the decompressed PNG data stream one byte per request on
// the input channel and rebuilds the filtered samples of each scanline. The
// first byte of every scanline is its filter code (None, Sub, Up, Average or
// Paeth); a valid code produces no result, while a code above four produces
// one result with bad_filter set and pixel_byte zero, and the row is then
// decoded as None. Each later byte comes out as one result carrying row_end
// on the last sample of a row and image_end on the last sample of the image.
// Setting start_of_image on a byte abandons any partial row and takes that
// byte as the filter code of row zero. The block sustains one byte per clock
// cycle unless the output stalls: a front end classifies each byte and
// keeps the column and row counts, a four-entry queue decouples it from the
// back end, and the back end issues the line-buffer read for the queue head
// as it enters the back-end stage register, ahead of reconstruction, so the
// single-port-read line buffer and the predictor never hold the stream. A
// sample passes the queue, the stage register and the output register, and
// is taken when i_out_stall is low. The output is registered, so the input
// keeps taking bytes while a result waits, until the queue fills. The line
// buffer holds MAX_WIDTH * MAX_PIXEL_BYTES bytes, needs no clearing after
// reset, and is valid row by row as each row is written. Configuration
// registers (0 image_width, 1 image_height, 2 pixel_bytes) are always ready
// and should be written only between images or while the block is idle.
module png_scanline_unfilter import psu_pkg::*; #(
    parameter int MAX_WIDTH       = 4096,
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_stream_byte,
    input  wire logic        i_start_of_image,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_pixel_byte,
    output logic             o_row_end,
    output logic             o_image_end,
    output logic             o_bad_filter,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // Address width of the line buffer, which holds one full row.
    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_PIXEL_BYTES);

    logic [12:0] r_cfg_width;
    logic [15:0] r_cfg_height;
    logic [2:0]  r_cfg_pixb;

    logic              q_full;
    logic              q_push;
    t_item             q_in_item;
    logic [ADDR_W-1:0] q_in_col;
    logic              q_valid;
    t_item             q_out_item;
    logic [ADDR_W-1:0] q_out_col;
    logic              q_pop;

    // Configuration writes are taken in any cycle; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 13'd1;
            r_cfg_height <= 16'd1;
            r_cfg_pixb   <= 3'd4;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data[12:0];
                CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_PIXB:   r_cfg_pixb   <= i_cfg_data[2:0];
                default:    r_cfg_width  <= r_cfg_width;
            endcase
        end
    end

    // The front end tracks position in the image and tags each sample with
    // its filter, byte lane, first-of-row and end flags so the back end never
    // needs the configuration.
    psu_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .ADDR_W          (ADDR_W)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_stream_byte    (i_stream_byte),
        .i_start_of_image (i_start_of_image),
        .i_cfg_width      (r_cfg_width),
        .i_cfg_height     (r_cfg_height),
        .i_cfg_pixb       (r_cfg_pixb),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_item           (q_in_item),
        .o_col            (q_in_col)
    );

    psu_queue #(
        .COL_W (ADDR_W)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_item    (q_in_item),
        .i_col     (q_in_col),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_item    (q_out_item),
        .o_col     (q_out_col),
        .i_pop     (q_pop)
    );

    // The back end owns the line buffer and the left and upper-left bytes.
    // Items leave the queue in order, so a row's write always lands before
    // the next row reads the same column.
    psu_back #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .ADDR_W          (ADDR_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_out_item),
        .i_q_col      (q_out_col),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_byte (o_pixel_byte),
        .o_row_end    (o_row_end),
        .o_image_end  (o_image_end),
        .o_bad_filter (o_bad_filter)
    );

endmodule
`default_nettype wire

// File: rtl/psu_front.sv
// Front end: parses the byte stream into filter codes and samples and tracks position.
`default_nettype none
module psu_front import psu_pkg::*; #(
    parameter int MAX_WIDTH       = 4096,
    parameter int MAX_PIXEL_BYTES = 4,
    parameter int ADDR_W          = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_stream_byte,
    input  wire logic              i_start_of_image,
    input  wire logic [12:0]       i_cfg_width,
    input  wire logic [15:0]       i_cfg_height,
    input  wire logic [2:0]        i_cfg_pixb,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_item                  o_item,
    output logic [ADDR_W-1:0]      o_col
);

    localparam logic [15:0] MaxW  = 16'(MAX_WIDTH);
    localparam logic [2:0]  MaxPb = 3'(MAX_PIXEL_BYTES);

    logic              r_await, n_await;
    logic [2:0]        r_filter, n_filter;
    logic [ADDR_W-1:0] r_col, n_col;
    logic [1:0]        r_k3, n_k3;
    logic [15:0]       r_row, n_row;
    logic              r_first, n_first;

    logic        accept;
    logic        take_code;
    logic        code_bad;
    logic [15:0] w_eff;
    logic [2:0]  pb_eff;
    logic [18:0] row_len;
    logic        last_col;
    logic        last_row;
    logic [LANE_W-1:0] lane;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign take_code = r_await || i_start_of_image;
    assign code_bad  = i_stream_byte > FILT_CODE_MAX;

    always_comb begin
        w_eff = {3'b000, i_cfg_width};
        if (w_eff == 16'd0) begin
            w_eff = 16'd1;
        end else if (w_eff > MaxW) begin
            w_eff = MaxW;
        end
        pb_eff = i_cfg_pixb;
        if (pb_eff < 3'd3) begin
            pb_eff = 3'd3;
        end else if (pb_eff > MaxPb) begin
            pb_eff = MaxPb;
        end
    end

    assign row_len  = 19'(w_eff) * 19'(pb_eff);
    assign last_col = (19'(r_col) + 19'd1) >= row_len;
    assign last_row = (i_cfg_height == 16'd0) ||
                      (({1'b0, r_row} + 17'd1) >= {1'b0, i_cfg_height});
    // Lane for three-byte pixels comes from a wrapping counter; for four it is the low bits.
    assign lane = (pb_eff == 3'd3) ? r_k3 : r_col[LANE_W-1:0];

    always_comb begin
        n_await  = r_await;
        n_filter = r_filter;
        n_col    = r_col;
        n_k3     = r_k3;
        n_row    = r_row;
        n_first  = r_first;
        o_push   = 1'b0;
        o_item   = '0;
        o_col    = r_col;
        if (accept) begin
            if (i_start_of_image) begin
                n_row = 16'd0;
            end
            if (take_code) begin
                n_filter = code_bad ? FILT_NONE : i_stream_byte[2:0];
                n_col    = '0;
                n_k3     = 2'd0;
                n_await  = 1'b0;
                n_first  = 1'b1;
                if (code_bad) begin
                    o_push     = 1'b1;
                    o_item.bad = 1'b1;
                end
            end else begin
                o_push            = 1'b1;
                o_item.data       = i_stream_byte;
                o_item.filter     = r_filter;
                o_item.lane       = lane;
                o_item.above_zero = (r_row == 16'd0);
                o_item.first      = r_first;
                o_item.row_end    = last_col;
                o_item.image_end  = last_col && last_row;
                n_first           = 1'b0;
                if (last_col) begin
                    n_await = 1'b1;
                    n_col   = '0;
                    n_k3    = 2'd0;
                    n_row   = last_row ? 16'd0 : r_row + 16'd1;
                end else begin
                    n_col = r_col + 1'b1;
                    n_k3  = (r_k3 == 2'd2) ? 2'd0 : r_k3 + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await  <= 1'b1;
            r_filter <= FILT_NONE;
            r_col    <= '0;
            r_k3     <= 2'd0;
            r_row    <= 16'd0;
            r_first  <= 1'b0;
        end else begin
            r_await  <= n_await;
            r_filter <= n_filter;
            r_col    <= n_col;
            r_k3     <= n_k3;
            r_row    <= n_row;
            r_first  <= n_first;
        end
    end

endmodule
`default_nettype wire

// File: rtl/psu_queue.sv
// Small FIFO of classified items between the front end and the reconstruction back end.
`default_nettype none
module psu_queue import psu_pkg::*; #(
    parameter int COL_W = 14
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire t_item            i_item,
    input  wire logic [COL_W-1:0] i_col,
    output logic                  o_full,
    output logic                  o_valid,
    output t_item                 o_item,
    output logic [COL_W-1:0]      o_col,
    input  wire logic             i_pop
);

    t_item             r_items [QUEUE_DEPTH];
    logic [COL_W-1:0]  r_cols  [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_items[r_rd];
    assign o_col   = r_cols[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_items[r_wr] <= i_item;
            r_cols[r_wr]  <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/psu_back.sv
// Back end: line buffer, neighbor registers, predictor and the output register.
`default_nettype none
module psu_back import psu_pkg::*; #(
    parameter int MAX_WIDTH       = 4096,
    parameter int MAX_PIXEL_BYTES = 4,
    parameter int ADDR_W          = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire t_item             i_q_item,
    input  wire logic [ADDR_W-1:0] i_q_col,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [7:0]             o_pixel_byte,
    output logic                   o_row_end,
    output logic                   o_image_end,
    output logic                   o_bad_filter
);

    localparam int CAP = MAX_WIDTH * MAX_PIXEL_BYTES;

    logic [7:0] r_line [CAP];

    logic              r_b1_valid;
    t_item             r_b1_item;
    logic [ADDR_W-1:0] r_b1_col;
    logic [7:0]        r_above;

    logic [7:0] r_left  [MAX_PIXEL_BYTES];
    logic [7:0] r_upper [MAX_PIXEL_BYTES];

    logic       r_out_valid;
    logic [7:0] r_out_pixel;
    logic       r_out_row_end;
    logic       r_out_image_end;
    logic       r_out_bad;

    logic       xfer;
    logic       line_we;
    logic [7:0] a_val, b_val, c_val;
    logic [8:0] ab_sum;
    logic [7:0] pred;
    logic [7:0] rec;

    assign xfer    = r_b1_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = i_q_valid && (!r_b1_valid || xfer);
    assign line_we = xfer && !r_b1_item.bad;

    assign a_val  = r_b1_item.first ? 8'd0 : r_left[r_b1_item.lane];
    assign c_val  = r_b1_item.first ? 8'd0 : r_upper[r_b1_item.lane];
    assign b_val  = r_b1_item.above_zero ? 8'd0 : r_above;
    assign ab_sum = {1'b0, a_val} + {1'b0, b_val};

    always_comb begin
        unique case (r_b1_item.filter)
            FILT_SUB:   pred = a_val;
            FILT_UP:    pred = b_val;
            FILT_AVG:   pred = ab_sum[8:1];
            FILT_PAETH: pred = paeth_pred(a_val, b_val, c_val);
            default:    pred = 8'd0;
        endcase
    end

    assign rec = r_b1_item.data + pred;

    // Line buffer: read for the queue head as it enters, written as the sample completes.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_above <= r_line[i_q_col];
        end
        if (line_we) begin
            r_line[r_b1_col] <= rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b1_item <= i_q_item;
            r_b1_col  <= i_q_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_b1_valid <= 1'b1;
        end else if (xfer) begin
            r_b1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]  <= 8'd0;
                r_upper[i] <= 8'd0;
            end
        end else if (line_we) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                if (r_b1_item.lane == LANE_W'(i)) begin
                    r_left[i]  <= rec;
                    r_upper[i] <= b_val;
                end else if (r_b1_item.first) begin
                    r_left[i]  <= 8'd0;
                    r_upper[i] <= 8'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_out_pixel     <= r_b1_item.bad ? 8'd0 : rec;
            r_out_row_end   <= r_b1_item.row_end;
            r_out_image_end <= r_b1_item.image_end;
            r_out_bad       <= r_b1_item.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_byte = r_out_pixel;
    assign o_row_end    = r_out_row_end;
    assign o_image_end  = r_out_image_end;
    assign o_bad_filter = r_out_bad;

`include "png_scanline_unfilter_assert.svh"

    `PSU_ASSERT_IMP(a_bad_report_clean, i_clk, i_rst_n, r_out_valid && r_out_bad, !r_out_row_end && !r_out_image_end && r_out_pixel == 8'd0)
    `PSU_ASSERT_IMP(a_image_end_is_row_end, i_clk, i_rst_n, r_out_valid && r_out_image_end, r_out_row_end)
    `PSU_ASSERT_IMP(a_no_write_when_blocked, i_clk, i_rst_n, r_out_valid && i_out_stall, !line_we)
    `PSU_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_b1_valid && r_out_valid && i_out_stall, r_b1_valid)

endmodule
`default_nettype wire
